// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds in the same cycle implies b
`define AFD_ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b on the next cycle
`define AFD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/afd_pkg.sv =====
`timescale 1ns / 1ps

package afd_pkg;

    localparam logic [7:0] DELIM_BYTE = 8'h7E;
    localparam logic [7:0] CSUM_BASE  = 8'hFF;
    localparam logic [15:0] MAX_LEN_RESET = 16'hFFFF;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NODELIM = 3'd1,
        ST_TRUNC   = 3'd2,
        ST_LONG    = 3'd3,
        ST_BADCS   = 3'd4
    } t_status;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [15:0] payload_position;
        logic [2:0]  frame_status;
        logic [15:0] frame_length;
    } t_result;

endpackage

// ===== hw/rtl/afd_in_if.sv =====
`timescale 1ns / 1ps

interface afd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_buffer;

    modport source (output valid, output data_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input data_byte, input end_of_buffer, output ready);
endinterface

// ===== hw/rtl/afd_out_if.sv =====
`timescale 1ns / 1ps

interface afd_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_position;
    logic [2:0]  frame_status;
    logic [15:0] frame_length;

    modport source (output valid, output result_kind, output payload_byte,
                    output payload_position, output frame_status, output frame_length,
                    input ready);
    modport sink   (input valid, input result_kind, input payload_byte,
                    input payload_position, input frame_status, input frame_length,
                    output ready);
endinterface

// ===== hw/rtl/afd_parser.sv =====
`timescale 1ns / 1ps

module afd_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_data_byte,
    input  logic             i_end_of_buffer,
    input  logic             i_cfg_we,
    input  logic [15:0]      i_cfg_data,
    output logic             o_res_valid,
    output afd_pkg::t_result o_res
);
    import afd_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        PH_HUNT    = 3'd0,
        PH_LENHI   = 3'd1,
        PH_LENLO   = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_CSUM    = 3'd4,
        PH_DONE    = 3'd5,
        PH_SKIP    = 3'd6,
        PH_SKIPCS  = 3'd7
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_len, n_len;
    logic [15:0] r_seen, n_seen;
    logic [7:0]  r_sum, n_sum;
    logic [15:0] r_max;

    logic        stat_fire;
    t_status     stat_code;
    logic [15:0] stat_len;
    logic        pay_fire;
    logic [15:0] seen_inc;
    logic [15:0] len_full;
    logic [7:0]  want_sum;

    assign seen_inc = r_seen + 16'd1;
    assign len_full = {r_len[15:8], i_data_byte};
    assign want_sum = CSUM_BASE - r_sum;

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_seen    = r_seen;
        n_sum     = r_sum;
        stat_fire = 1'b0;
        stat_code = ST_OK;
        stat_len  = 16'd0;
        pay_fire  = 1'b0;
        unique case (r_phase)
            PH_HUNT: begin
                if (i_data_byte == DELIM_BYTE) begin
                    n_len  = 16'd0;
                    n_seen = 16'd0;
                    n_sum  = 8'd0;
                    if (i_end_of_buffer) begin
                        stat_fire = 1'b1;
                        stat_code = ST_TRUNC;
                    end else begin
                        n_phase = PH_LENHI;
                    end
                end else if (i_end_of_buffer) begin
                    stat_fire = 1'b1;
                    stat_code = ST_NODELIM;
                end
            end
            PH_LENHI: begin
                if (i_end_of_buffer) begin
                    stat_fire = 1'b1;
                    stat_code = ST_TRUNC;
                end else begin
                    n_len   = {i_data_byte, 8'd0};
                    n_phase = PH_LENLO;
                end
            end
            PH_LENLO: begin
                n_len = len_full;
                if (i_end_of_buffer) begin
                    stat_fire = 1'b1;
                    stat_code = ST_TRUNC;
                    stat_len  = len_full;
                end else begin
                    n_seen = 16'd0;
                    n_sum  = 8'd0;
                    // limit is sampled once, here
                    if (len_full > r_max) begin
                        n_phase = (len_full == 16'd0) ? PH_SKIPCS : PH_SKIP;
                    end else begin
                        n_phase = (len_full == 16'd0) ? PH_CSUM : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (i_end_of_buffer) begin
                    stat_fire = 1'b1;
                    stat_code = ST_TRUNC;
                    stat_len  = r_len;
                end else begin
                    pay_fire = 1'b1;
                    n_sum    = r_sum + i_data_byte;
                    n_seen   = seen_inc;
                    if (seen_inc == r_len) begin
                        n_phase = PH_CSUM;
                    end
                end
            end
            PH_CSUM: begin
                stat_fire = 1'b1;
                stat_code = (want_sum == i_data_byte) ? ST_OK : ST_BADCS;
                stat_len  = r_len;
            end
            PH_SKIP: begin
                if (i_end_of_buffer) begin
                    stat_fire = 1'b1;
                    stat_code = ST_TRUNC;
                    stat_len  = r_len;
                end else begin
                    n_seen = seen_inc;
                    if (seen_inc == r_len) begin
                        n_phase = PH_SKIPCS;
                    end
                end
            end
            PH_SKIPCS: begin
                stat_fire = 1'b1;
                stat_code = ST_LONG;
                stat_len  = r_len;
            end
            PH_DONE: begin
                if (i_end_of_buffer) begin
                    n_len   = 16'd0;
                    n_seen  = 16'd0;
                    n_sum   = 8'd0;
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                n_phase = PH_HUNT;
            end
        endcase
        if (stat_fire) begin
            n_len   = 16'd0;
            n_seen  = 16'd0;
            n_sum   = 8'd0;
            n_phase = i_end_of_buffer ? PH_HUNT : PH_DONE;
        end
    end

    always_comb begin
        o_res_valid = i_accept && (stat_fire || pay_fire);
        o_res       = '0;
        if (stat_fire) begin
            o_res.result_kind  = KIND_STATUS;
            o_res.frame_status = stat_code;
            o_res.frame_length = stat_len;
        end else begin
            o_res.result_kind      = KIND_PAYLOAD;
            o_res.payload_byte     = i_data_byte;
            o_res.payload_position = r_seen;
            o_res.frame_length     = r_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= 16'd0;
            r_seen  <= 16'd0;
            r_sum   <= 8'd0;
            r_max   <= MAX_LEN_RESET;
        end else begin
            if (i_accept) begin
                r_phase <= n_phase;
                r_len   <= n_len;
                r_seen  <= n_seen;
                r_sum   <= n_sum;
            end
            if (i_cfg_we) begin
                r_max <= i_cfg_data;
            end
        end
    end

    `AFD_ASSERT_IMPL(a_payload_status_ok, i_clk, i_rst_n,
        o_res_valid && (o_res.result_kind == KIND_PAYLOAD), o_res.frame_status == ST_OK)
    `AFD_ASSERT_NEXT(a_hunt_after_last, i_clk, i_rst_n,
        i_accept && i_end_of_buffer, r_phase == PH_HUNT)
    `AFD_ASSERT_IMPL(a_seen_below_len, i_clk, i_rst_n,
        r_phase == PH_PAYLOAD, r_seen < r_len)

endmodule

// ===== hw/rtl/afd_out_reg.sv =====
`timescale 1ns / 1ps

module afd_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  afd_pkg::t_result i_res,
    input  logic             i_ready,
    output logic             o_valid,
    output afd_pkg::t_result o_res,
    output logic             o_can_take
);
    import afd_pkg::*;
    `include "assert_macros.svh"

    logic    r_valid;
    t_result r_res;

    // slot frees up in the same cycle the consumer takes it
    assign o_can_take = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_res      = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_load) begin
            r_res <= i_res;
        end
    end

    `AFD_ASSERT_NEXT(a_stalled_result_held, i_clk, i_rst_n,
        r_valid && !i_ready, r_valid && $stable(r_res))

endmodule

// ===== hw/rtl/api_frame_deframer.sv =====
`timescale 1ns / 1ps
// A result is registered once: it appears on o_out in the cycle after the byte that causes it
// is accepted. Throughput: one byte per cycle while the output slot is free; the parser state
// updates on each accepted byte, the single output register whenever its slot is free, and input
// ready follows the output register's slot. Reset (synchronous, active low): parser hunts for a
// delimiter, length limit is 65535, output register empty.

module api_frame_deframer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    afd_in_if.sink       i_in,
    afd_out_if.source    o_out,
    input  logic         i_cfg_we,
    input  logic [15:0]  i_cfg_data
);
    import afd_pkg::*;

    logic    can_take;
    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign i_in.ready = can_take;
    assign accept     = i_in.valid && can_take;

    afd_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_data_byte     (i_in.data_byte),
        .i_end_of_buffer (i_in.end_of_buffer),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .o_res_valid     (res_valid),
        .o_res           (res)
    );

    afd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (res_valid),
        .i_res      (res),
        .i_ready    (o_out.ready),
        .o_valid    (o_out.valid),
        .o_res      (out_res),
        .o_can_take (can_take)
    );

    assign o_out.result_kind      = out_res.result_kind;
    assign o_out.payload_byte     = out_res.payload_byte;
    assign o_out.payload_position = out_res.payload_position;
    assign o_out.frame_status     = out_res.frame_status;
    assign o_out.frame_length     = out_res.frame_length;

endmodule

// ===== verif/api_frame_deframer_test.sv =====
`timescale 1ns / 1ps

module api_frame_deframer_test;
    import afd_pkg::*;

    typedef enum logic [2:0] {
        HUNTING,
        LEN_HIGH,
        LEN_LOW,
        IN_PAYLOAD,
        AT_CHECKSUM,
        IGNORING,
        SKIP_BODY,
        SKIP_CHECKSUM
    } t_parse_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [15:0] i_cfg_data = '0;

    afd_in_if  in_ch();
    afd_out_if out_ch();

    api_frame_deframer i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // predictor state
    t_parse_phase pred_phase = HUNTING;
    logic [15:0]  pred_length = '0;
    logic [15:0]  pred_count = '0;
    logic [7:0]   pred_sum = '0;
    logic [15:0]  pred_limit = MAX_LEN_RESET;

    t_result    expected_results[$];
    logic [7:0] tx_bytes[$];
    int         error_count = 0;
    int         bytes_sent = 0;
    bit         idle_on = 1'b1;
    int         rx_hold = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.end_of_buffer = 1'b0;
        out_ch.ready = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_error(input string what);
        error_count++;
        if (error_count <= 50) begin
            $display("ERROR @%0t: %s", $time, what);
        end
    endtask

    // ---------------- predictor ----------------

    function automatic void close_frame(input t_status st, input logic [15:0] len,
                                        input logic last);
        t_result r;
        r = '0;
        r.result_kind = KIND_STATUS;
        r.frame_status = st;
        r.frame_length = len;
        expected_results.push_back(r);
        pred_length = '0;
        pred_count = '0;
        pred_sum = '0;
        pred_phase = last ? HUNTING : IGNORING;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b, input logic last);
        t_result    r;
        logic [7:0] want_sum;
        r = '0;
        case (pred_phase)
            HUNTING: begin
                if (b == DELIM_BYTE) begin
                    pred_length = '0;
                    pred_count = '0;
                    pred_sum = '0;
                    if (last) close_frame(ST_TRUNC, '0, 1'b1);
                    else pred_phase = LEN_HIGH;
                end else if (last) begin
                    close_frame(ST_NODELIM, '0, 1'b1);
                end
            end
            LEN_HIGH: begin
                if (last) begin
                    close_frame(ST_TRUNC, '0, 1'b1);
                end else begin
                    pred_length = {b, 8'h00};
                    pred_phase = LEN_LOW;
                end
            end
            LEN_LOW: begin
                pred_length = {pred_length[15:8], b};
                if (last) begin
                    close_frame(ST_TRUNC, pred_length, 1'b1);
                end else begin
                    pred_count = '0;
                    pred_sum = '0;
                    // a zero length can never exceed the limit
                    if (pred_length > pred_limit) pred_phase = SKIP_BODY;
                    else if (pred_length == 0) pred_phase = AT_CHECKSUM;
                    else pred_phase = IN_PAYLOAD;
                end
            end
            IN_PAYLOAD: begin
                if (last) begin
                    close_frame(ST_TRUNC, pred_length, 1'b1);
                end else begin
                    r.result_kind = KIND_PAYLOAD;
                    r.payload_byte = b;
                    r.payload_position = pred_count;
                    r.frame_status = ST_OK;
                    r.frame_length = pred_length;
                    expected_results.push_back(r);
                    pred_sum = pred_sum + b;
                    pred_count = pred_count + 16'd1;
                    if (pred_count == pred_length) pred_phase = AT_CHECKSUM;
                end
            end
            AT_CHECKSUM: begin
                want_sum = CSUM_BASE - pred_sum;
                if (want_sum == b) close_frame(ST_OK, pred_length, last);
                else close_frame(ST_BADCS, pred_length, last);
            end
            SKIP_BODY: begin
                if (last) begin
                    close_frame(ST_TRUNC, pred_length, 1'b1);
                end else begin
                    pred_count = pred_count + 16'd1;
                    if (pred_count == pred_length) pred_phase = SKIP_CHECKSUM;
                end
            end
            SKIP_CHECKSUM: begin
                close_frame(ST_LONG, pred_length, last);
            end
            default: begin
                if (last) begin
                    pred_length = '0;
                    pred_count = '0;
                    pred_sum = '0;
                    pred_phase = HUNTING;
                end
            end
        endcase
    endfunction

    // ---------------- result checking ----------------

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_results.size() == 0) begin
                report_error($sformatf("unexpected result kind=%0d status=%0d len=%0d",
                    out_ch.result_kind, out_ch.frame_status, out_ch.frame_length));
            end else begin
                want = expected_results.pop_front();
                if (out_ch.result_kind !== want.result_kind)
                    report_error($sformatf("result_kind got %0d want %0d",
                        out_ch.result_kind, want.result_kind));
                if (out_ch.payload_byte !== want.payload_byte)
                    report_error($sformatf("payload_byte got %02h want %02h",
                        out_ch.payload_byte, want.payload_byte));
                if (out_ch.payload_position !== want.payload_position)
                    report_error($sformatf("payload_position got %0d want %0d",
                        out_ch.payload_position, want.payload_position));
                if (out_ch.frame_status !== want.frame_status)
                    report_error($sformatf("frame_status got %0d want %0d",
                        out_ch.frame_status, want.frame_status));
                if (out_ch.frame_length !== want.frame_length)
                    report_error($sformatf("frame_length got %0d want %0d",
                        out_ch.frame_length, want.frame_length));
            end
        end
    end

    // result side: random stalls per result while idle_on is set, plus a long hold on request
    initial begin : result_sink
        int k;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold > 0) begin
                out_ch.ready <= 1'b0;
                repeat (rx_hold) @(negedge i_clk);
                rx_hold = 0;
            end else begin
                k = idle_on ? $urandom_range(0, 13) : 0;
                if (k != 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (k) @(negedge i_clk);
                end
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_ch.valid && out_ch.ready) && rx_hold == 0);
            @(negedge i_clk);
        end
    end

    // ---------------- stimulus helpers ----------------

    // returns at a falling edge with valid still high, so a back-to-back request
    // needs no second assignment in the same step
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.end_of_buffer <= last;
        do @(posedge i_clk); while (!in_ch.ready);
        deframe_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_buffer();
        foreach (tx_bytes[i]) send_byte(tx_bytes[i], i == tx_bytes.size() - 1);
    endtask

    task automatic wait_drain();
        in_ch.valid <= 1'b0;
        while (expected_results.size() != 0) @(negedge i_clk);
        // a byte with no result may still be in flight
        repeat (3) @(negedge i_clk);
    endtask

    task automatic set_max_length(input logic [15:0] v);
        wait_drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        pred_limit = v;
    endtask

    function automatic void build_frame(input int len, input int body, input bit with_csum,
                                        input bit good_csum, input int lead, input int trail);
        logic [7:0] v;
        logic [7:0] sum;
        tx_bytes.delete();
        sum = '0;
        repeat (lead) begin
            v = 8'($urandom_range(0, 255));
            if (v == DELIM_BYTE) v = 8'h00;
            tx_bytes.push_back(v);
        end
        tx_bytes.push_back(DELIM_BYTE);
        tx_bytes.push_back(len[15:8]);
        tx_bytes.push_back(len[7:0]);
        repeat (body) begin
            v = 8'($urandom_range(0, 255));
            sum = sum + v;
            tx_bytes.push_back(v);
        end
        if (with_csum) begin
            v = CSUM_BASE - sum;
            if (!good_csum) v = v ^ 8'($urandom_range(1, 255));
            tx_bytes.push_back(v);
        end
        repeat (trail) tx_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    task automatic send_random_buffer();
        int pick, len, cap, lead, trail, cut;
        pick = $urandom_range(0, 99);
        cap = (pred_limit < 16'd24) ? int'(pred_limit) : 24;
        lead = ($urandom_range(0, 9) < 3) ? $urandom_range(1, 3) : 0;
        trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        if (pick < 65 || (pick >= 85 && pred_limit == 16'hFFFF)) begin
            len = $urandom_range(0, cap);
            build_frame(len, len, 1'b1, $urandom_range(0, 9) != 0, lead, trail);
        end else if (pick < 75) begin
            // buffer ends early; half of these carry a random 16-bit length
            len = $urandom_range(0, 1) ? $urandom_range(0, 65535) : $urandom_range(0, cap);
            build_frame(len, (len < 6) ? len : 6, 1'b0, 1'b0, lead, 0);
            cut = $urandom_range(1, tx_bytes.size());
            while (tx_bytes.size() > cut) void'(tx_bytes.pop_back());
        end else if (pick < 85) begin
            tx_bytes.delete();
            repeat ($urandom_range(1, 8)) tx_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            len = int'(pred_limit) + int'($urandom_range(1, 8));
            if (len > 65535) len = 65535;
            build_frame(len, len, 1'b1, 1'b1, lead, trail);
        end
        send_buffer();
    endtask

    // ---------------- tests ----------------

    task automatic test_directed_cases();
        idle_on = 1'b1;
        tx_bytes = '{8'h00, 8'hFF};                         // no delimiter
        send_buffer();
        tx_bytes = '{DELIM_BYTE};                           // ends right after delimiter
        send_buffer();
        tx_bytes = '{DELIM_BYTE, 8'h00, 8'h00, 8'hFF};     // zero length
        send_buffer();
        // one byte, good checksum, delimiter in the ignored tail
        tx_bytes = '{DELIM_BYTE, 8'h00, 8'h01, 8'hAB, 8'h54, DELIM_BYTE};
        send_buffer();
        tx_bytes = '{DELIM_BYTE, 8'h00, 8'h01, 8'h01, 8'h00}; // bad checksum
        send_buffer();
        tx_bytes = '{DELIM_BYTE, 8'hFF, 8'hFF};             // cut in the length
        send_buffer();
        set_max_length(16'd0);
        tx_bytes = '{DELIM_BYTE, 8'h00, 8'h02, 8'hAA, 8'hBB, 8'hCC}; // over the limit
        send_buffer();
        set_max_length(MAX_LEN_RESET);
    endtask

    task automatic test_output_stall();
        idle_on = 1'b0;
        rx_hold = 240;
        repeat (3) begin
            build_frame(20, 20, 1'b1, 1'b1, 0, 0);
            send_buffer();
        end
        wait_drain();
    endtask

    task automatic test_random_traffic();
        logic [15:0] plan [7];
        int start;
        plan = '{16'hFFFF, 16'd16, 16'd0, 16'd1, 16'd40, 16'd255, 16'hFFFF};
        for (int p = 0; p < 7; p++) begin
            set_max_length(plan[p]);
            idle_on = (p % 2 == 0);
            start = bytes_sent;
            while (bytes_sent - start < 135) begin
                send_random_buffer();
                if ($urandom_range(0, 19) == 0) wait_drain();
            end
        end
        wait_drain();
    endtask

    initial begin : run_tests
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_output_stall();
        test_random_traffic();

        in_ch.valid <= 1'b0;
        for (int n = 0; n < 4000 && expected_results.size() != 0; n++) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (expected_results.size() != 0)
            report_error($sformatf("%0d expected results never arrived",
                expected_results.size()));
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/afd_pkg.sv
hw/rtl/afd_in_if.sv
hw/rtl/afd_out_if.sv
hw/rtl/afd_parser.sv
hw/rtl/afd_out_reg.sv
hw/rtl/api_frame_deframer.sv
verif/api_frame_deframer_test.sv
